// ----- rtl/core/bitmap_bit_allocator_defines.svh -----
// Assertion macros for the bitmap bit allocator checks.
`ifndef BITMAP_BIT_ALLOCATOR_DEFINES_SVH
`define BITMAP_BIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bba_pkg.sv -----
`default_nettype none

package bba_pkg;

  localparam int WORD_BITS = 64;
  localparam int MAP_BITS  = 1024;
  localparam int NUM_WORDS = MAP_BITS / WORD_BITS;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int BPOS_W    = $clog2(WORD_BITS);
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int CMD_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TEST_SET   = 3'd0,
    CMD_TEST_CLEAR = 3'd1,
    CMD_ALLOCATE   = 3'd2,
    CMD_NEXT_SET   = 3'd3,
    CMD_COUNT      = 3'd4,
    CMD_SET_PREFIX = 3'd5
  } cmd_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture input item, restart scan
    logic step;      // process one word of the current command
    logic post;      // move result into output register
    logic cfg_load;  // capture new length
    logic clr_step;  // trim one word to the length
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic done;      // current step is the last one of the command
    logic last;      // word counter at final word
    logic out_free;  // output register can take a result
  } dp_sts_t;

  // Bits of word w that lie below n
  function automatic logic [WORD_BITS-1:0] word_mask(input logic [WADDR_W-1:0] w,
                                                     input logic [CNT_W-1:0]   n);
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] rem;
    logic [WORD_BITS-1:0] m;
    base = CNT_W'({w, {BPOS_W{1'b0}}});
    rem  = n - base;
    if (n >= base + CNT_W'(WORD_BITS)) begin
      m = '1;
    end else if (n <= base) begin
      m = '0;
    end else begin
      m = {WORD_BITS{1'b1}} >> ((BPOS_W+1)'(WORD_BITS) - {1'b0, rem[BPOS_W-1:0]});
    end
    return m;
  endfunction

  function automatic logic [BPOS_W:0] pop_count(input logic [WORD_BITS-1:0] w);
    logic [BPOS_W:0] c;
    c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c + (BPOS_W+1)'(w[i]);
    end
    return c;
  endfunction

  // Position of the lowest set bit
  function automatic logic [BPOS_W-1:0] first_one(input logic [WORD_BITS-1:0] w);
    logic [BPOS_W-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        p = BPOS_W'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bitmap_bit_allocator.sv -----
// Channel   Direction  Handshake          Payload
// in        input      in_valid/stall     command, bit_index, prefix_count
// out       output     out_valid/stall    old_bit, found, found_index, set_count, range_error
// cfg       input      cfg_valid/ready    used_bits
//
// An item is transferred while idle, then takes 1 step (test commands, unknown codes)
// or up to 16 steps (allocate, search, count, prefix: one map word per step),
// then loads the output register once that register is free.
// A length write starts a sweep over all 16 map words that trims the map to the new length.
// Reset clears the map and sets the length to 1024.
// A stalled result sits in the output register; the next item is taken meanwhile.
`default_nettype none

module bitmap_bit_allocator
  import bba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [IDX_W-1:0]  bit_index_i,
  input  wire logic [CNT_W-1:0]  prefix_count_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   old_bit_o,
  output logic                   found_o,
  output logic [IDX_W-1:0]       found_index_o,
  output logic [CNT_W-1:0]       set_count_o,
  output logic                   range_error_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CNT_W-1:0]  used_bits_i
);

  dp_ctrl_t ctrl;
  dp_sts_t  sts;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .ctrl_o      (ctrl),
    .sts_i       (sts)
  );

  bba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .sts_o          (sts),
    .command_i      (command_i),
    .bit_index_i    (bit_index_i),
    .prefix_count_i (prefix_count_i),
    .used_bits_i    (used_bits_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .old_bit_o      (old_bit_o),
    .found_o        (found_o),
    .found_index_o  (found_index_o),
    .set_count_o    (set_count_o),
    .range_error_o  (range_error_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/bba_ctrl.sv -----
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  output dp_ctrl_t      ctrl_o,
  input  wire dp_sts_t  sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_CLEAR,
    ST_POST
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          ctrl_o.cfg_load = 1'b1;
          state_d         = ST_CLEAR;
        end else if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_RUN;
        end
      end
      ST_RUN: begin
        ctrl_o.step = 1'b1;
        if (sts_i.done) begin
          state_d = ST_POST;
        end
      end
      ST_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
        if (sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_POST: begin
        if (sts_i.out_free) begin
          ctrl_o.post = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Config takes priority over items in idle
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bba_dp.sv -----
`default_nettype none

module bba_dp
  import bba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_ctrl_t          ctrl_i,
  output dp_sts_t                sts_o,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [IDX_W-1:0]  bit_index_i,
  input  wire logic [CNT_W-1:0]  prefix_count_i,
  input  wire logic [CNT_W-1:0]  used_bits_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output logic                   old_bit_o,
  output logic                   found_o,
  output logic [IDX_W-1:0]       found_index_o,
  output logic [CNT_W-1:0]       set_count_o,
  output logic                   range_error_o
);

  logic [WORD_BITS-1:0] map_q [NUM_WORDS];
  logic [CNT_W-1:0]     len_q;
  logic [WADDR_W-1:0]   wcnt_q;
  logic                 out_valid_q;

  cmd_e                 cmd_q;
  logic [IDX_W-1:0]     idx_q;
  logic [CNT_W-1:0]     pfx_q;
  logic                 res_old_q, res_found_q, res_err_q;
  logic [IDX_W-1:0]     res_index_q;
  logic [CNT_W-1:0]     res_count_q;
  logic                 out_old_q, out_found_q, out_err_q;
  logic [IDX_W-1:0]     out_index_q;
  logic [CNT_W-1:0]     out_count_q;

  logic                 single;
  logic [WADDR_W-1:0]   rd_addr;
  logic [WADDR_W-1:0]   idx_word;
  logic [BPOS_W-1:0]    idx_bit;
  logic [WORD_BITS-1:0] word, live, above, cand;
  logic [BPOS_W-1:0]    pos;
  logic                 hit, tbit, terr;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic [CNT_W-1:0]     pfx_clamp;
  cmd_e                 cmd_in;

  assign idx_word = idx_q[IDX_W-1:BPOS_W];
  assign idx_bit  = idx_q[BPOS_W-1:0];
  assign cmd_in   = cmd_e'(command_i);

  // Test commands and unknown codes finish in one step
  assign single = (cmd_q != CMD_ALLOCATE) && (cmd_q != CMD_NEXT_SET) &&
                  (cmd_q != CMD_COUNT) && (cmd_q != CMD_SET_PREFIX);

  // Word read and scan candidates
  always_comb begin
    rd_addr = (ctrl_i.step && single) ? idx_word : wcnt_q;
    word    = map_q[rd_addr];
    live    = word_mask(rd_addr, len_q);
    above   = (rd_addr == idx_word) ? (({WORD_BITS{1'b1}} << idx_bit) << 1) : '1;
    cand    = (cmd_q == CMD_ALLOCATE) ? (~word & live) : (word & live & above);
    pos     = first_one(cand);
    hit     = ((cmd_q == CMD_ALLOCATE) || (cmd_q == CMD_NEXT_SET)) && (|cand);
    tbit    = word[idx_bit];
    terr    = ({1'b0, idx_q} >= len_q);
  end

  // Word write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_data = word;
    if (ctrl_i.clr_step) begin
      wr_en   = 1'b1;
      wr_data = word & live;
    end else if (ctrl_i.step) begin
      case (cmd_q)
        CMD_TEST_SET: begin
          wr_en   = !terr;
          wr_data = word | (WORD_BITS'(1) << idx_bit);
        end
        CMD_TEST_CLEAR: begin
          wr_en   = !terr;
          wr_data = word & ~(WORD_BITS'(1) << idx_bit);
        end
        CMD_ALLOCATE: begin
          wr_en   = hit;
          wr_data = word | (WORD_BITS'(1) << pos);
        end
        CMD_SET_PREFIX: begin
          wr_en   = 1'b1;
          wr_data = word_mask(rd_addr, pfx_q);
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign pfx_clamp = (prefix_count_i > len_q) ? len_q : prefix_count_i;

  assign sts_o.last     = (wcnt_q == {WADDR_W{1'b1}});
  assign sts_o.done     = single || hit || sts_o.last;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // Map store, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        map_q[i] <= '0;
      end
    end else if (wr_en) begin
      map_q[rd_addr] <= wr_data;
    end
  end

  // Length, word counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= CNT_W'(MAP_BITS);
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.cfg_load) begin
        len_q  <= (used_bits_i > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : used_bits_i;
        wcnt_q <= '0;
      end else if (ctrl_i.load) begin
        wcnt_q <= (cmd_in == CMD_NEXT_SET) ? bit_index_i[IDX_W-1:BPOS_W] : '0;
      end else if (ctrl_i.step || ctrl_i.clr_step) begin
        wcnt_q <= wcnt_q + WADDR_W'(1);
      end
      if (ctrl_i.post) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, partial result and output payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q       <= cmd_in;
      idx_q       <= bit_index_i;
      pfx_q       <= pfx_clamp;
      res_old_q   <= 1'b0;
      res_found_q <= 1'b0;
      res_err_q   <= 1'b0;
      res_index_q <= '0;
      res_count_q <= '0;
    end else if (ctrl_i.step) begin
      if ((cmd_q == CMD_TEST_SET) || (cmd_q == CMD_TEST_CLEAR)) begin
        res_old_q <= tbit && !terr;
        res_err_q <= terr;
      end
      if (hit) begin
        res_found_q <= 1'b1;
        res_index_q <= {rd_addr, pos};
      end
      if (cmd_q == CMD_COUNT) begin
        res_count_q <= res_count_q + CNT_W'(pop_count(word));
      end
    end
    if (ctrl_i.post) begin
      out_old_q   <= res_old_q;
      out_found_q <= res_found_q;
      out_err_q   <= res_err_q;
      out_index_q <= res_index_q;
      out_count_q <= res_count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign old_bit_o     = out_old_q;
  assign found_o       = out_found_q;
  assign found_index_o = out_index_q;
  assign set_count_o   = out_count_q;
  assign range_error_o = out_err_q;

endmodule

`default_nettype wire

// ----- rtl/core/bba_checker.sv -----
`default_nettype none
`include "bitmap_bit_allocator_defines.svh"

module bba_checker
  import bba_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              found_o,
  input wire logic [IDX_W-1:0]  found_index_o,
  input wire logic              old_bit_o,
  input wire logic [CNT_W-1:0]  set_count_o,
  input wire logic              range_error_o,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o
);

  // Stalled result holds
  `BBA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(found_index_o), "result changed under stall")

  // No index reported without a find
  `BBA_ASSERT_NOW(a_idx_zero, out_valid_o && !found_o, found_index_o == '0, "found_index set without found")

  // Range error excludes every other result
  `BBA_ASSERT_NOW(a_err_alone, out_valid_o && range_error_o, !old_bit_o && !found_o && (set_count_o == '0), "range error with other fields set")

  // Length write and item transfer never coincide, and the trim sweep follows
  `BBA_ASSERT_NOW(a_cfg_excl, cfg_valid_i && cfg_ready_o, in_stall_o, "item taken with length write")
  `BBA_ASSERT_NEXT(a_cfg_busy, cfg_valid_i && cfg_ready_o, !cfg_ready_o && in_stall_o, "ready during trim sweep")

endmodule

bind bitmap_bit_allocator bba_checker u_bba_checker (.*);

`default_nettype wire
